// ===== rtl/qbse_pkg.sv =====
// qbse_pkg: shared types and codes of the quadratic bezier spline evaluator
// no dependencies; used by qbse_ctrl, qbse_lane, qbse_datapath and the top level

package qbse_pkg;

    localparam int COORD_W = 32;
    localparam int NUM_AXES = 3;

    // item kinds carried on s_tuser
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_EVAL   = 1'b1;

    // result kinds carried on m_tuser
    localparam logic [1:0] STATUS_EVAL    = 2'd0;
    localparam logic [1:0] STATUS_STORED  = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_X  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_Y  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_Z  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_X = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_Y = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_Z = 3'd5;

    // datapath step issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PROD,
        OP_INDEX,
        OP_SQUARE,
        OP_WEIGHT,
        OP_MAC0,
        OP_MAC1,
        OP_MAC2,
        OP_MAC3,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        logic   take_item;
        dp_op_t op;
        logic   publish;
    } qbse_cmd_t;

    typedef struct packed {
        logic item_is_eval;
        logic table_empty;
        logic out_free;
    } qbse_stat_t;

endpackage

// ===== rtl/qbse_ctrl.sv =====
// qbse_ctrl: sequencing state machine of the spline evaluator
// depends on qbse_pkg; drives the datapath through qbse_cmd_t

module qbse_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  qbse_pkg::qbse_stat_t stat,
    output qbse_pkg::qbse_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_INDEX,
        S_SQUARE,
        S_WEIGHT,
        S_MAC0,
        S_MAC1,
        S_MAC2,
        S_MAC3,
        S_FINISH,
        S_PUBLISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    assign s_tready = ready_reg;

    always_comb
    begin
        cmd.take_item = (state_reg == S_IDLE) && s_tvalid && ready_reg;
        cmd.publish   = (state_reg == S_PUBLISH) && stat.out_free;
        cmd.op        = qbse_pkg::OP_NONE;
        state_next    = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.take_item)
                begin
                    if (stat.item_is_eval && !stat.table_empty)
                        state_next = S_PROD;
                    else
                        state_next = S_PUBLISH;
                end
            end
            S_PROD:
            begin
                cmd.op     = qbse_pkg::OP_PROD;
                state_next = S_INDEX;
            end
            S_INDEX:
            begin
                cmd.op     = qbse_pkg::OP_INDEX;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.op     = qbse_pkg::OP_SQUARE;
                state_next = S_WEIGHT;
            end
            S_WEIGHT:
            begin
                cmd.op     = qbse_pkg::OP_WEIGHT;
                state_next = S_MAC0;
            end
            S_MAC0:
            begin
                cmd.op     = qbse_pkg::OP_MAC0;
                state_next = S_MAC1;
            end
            S_MAC1:
            begin
                cmd.op     = qbse_pkg::OP_MAC1;
                state_next = S_MAC2;
            end
            S_MAC2:
            begin
                cmd.op     = qbse_pkg::OP_MAC2;
                state_next = S_MAC3;
            end
            S_MAC3:
            begin
                cmd.op     = qbse_pkg::OP_MAC3;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.op     = qbse_pkg::OP_FINISH;
                state_next = S_PUBLISH;
            end
            S_PUBLISH:
            begin
                if (cmd.publish)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    // an accepted request always leaves idle
    a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_item |=> (state_reg != S_IDLE))
        else $error("controller stayed idle after taking a request");

    // ready comes back only after a result went to the output register
    a_ready_after_publish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ready_reg) |-> $past(cmd.publish))
        else $error("ready rose without a published result");

endmodule

// ===== rtl/qbse_lane.sv =====
// qbse_lane: one coordinate lane, multiplier, accumulator, rounding and saturation
// depends on qbse_pkg for the datapath step codes

module qbse_lane #(
    parameter int T_FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  qbse_pkg::dp_op_t                  op,
    input  logic signed [T_FRAC_BITS+1:0]     wgt,
    input  logic signed [qbse_pkg::COORD_W-1:0] coord,
    input  logic signed [qbse_pkg::COORD_W-1:0] offset,
    output logic signed [T_FRAC_BITS+qbse_pkg::COORD_W+1:0] prod,
    output logic signed [qbse_pkg::COORD_W-1:0] pos
);

    localparam int F      = T_FRAC_BITS;
    localparam int CW     = qbse_pkg::COORD_W;
    localparam int PROD_W = F + 2 + CW;
    localparam int ACC_W  = PROD_W + 2;
    localparam int Q_W    = ACC_W - F;
    localparam int SUM_W  = Q_W + 1;
    localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [Q_W-1:0]    q;
    logic signed [SUM_W-1:0]  sum;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        case (op)
            qbse_pkg::OP_SQUARE,
            qbse_pkg::OP_MAC0,
            qbse_pkg::OP_MAC1,
            qbse_pkg::OP_MAC2: prod_reg <= wgt * coord;
            default: ;
        endcase
        case (op)
            qbse_pkg::OP_MAC1: acc_reg <= ACC_W'(prod_reg);
            qbse_pkg::OP_MAC2,
            qbse_pkg::OP_MAC3: acc_reg <= acc_reg + ACC_W'(prod_reg);
            default: ;
        endcase
    end

    // round half up, add offset, clamp to 32 bits
    always_comb
    begin
        rnd = acc_reg + HALF;
        q   = rnd[ACC_W-1:F];
        sum = SUM_W'(q) + SUM_W'(offset);
        if (sum[SUM_W-1:CW-1] == {(SUM_W-CW+1){1'b0}} ||
            sum[SUM_W-1:CW-1] == {(SUM_W-CW+1){1'b1}})
            pos = sum[CW-1:0];
        else if (sum[SUM_W-1])
            pos = {1'b1, {(CW-1){1'b0}}};
        else
            pos = {1'b0, {(CW-1){1'b1}}};
    end

endmodule

// ===== rtl/qbse_datapath.sv =====
// qbse_datapath: segment memories, config registers, index and weight logic, output register
// depends on qbse_pkg and qbse_lane

module qbse_datapath #(
    parameter int MAX_SEGMENTS = 16,
    parameter int T_FRAC_BITS  = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  qbse_pkg::qbse_cmd_t               cmd,
    output qbse_pkg::qbse_stat_t              stat,
    input  logic [((6*qbse_pkg::COORD_W+T_FRAC_BITS+1+7)/8)*8-1:0] s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [qbse_pkg::NUM_AXES*qbse_pkg::COORD_W-1:0] m_tdata,
    output logic [1:0]                        m_tuser,
    input  logic                              cfg_we,
    input  logic [qbse_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [qbse_pkg::COORD_W-1:0]      cfg_data
);

    localparam int F      = T_FRAC_BITS;
    localparam int CW     = qbse_pkg::COORD_W;
    localparam int NA     = qbse_pkg::NUM_AXES;
    localparam int PT_W   = NA * CW;
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int P_W    = F + 1 + CNT_W;
    localparam int WGT_W  = F + 2;
    localparam int PROD_W = F + 2 + CW;
    localparam int T_LSB  = 2 * PT_W;
    localparam int SQ_HALF = 1 << (F - 1);
    localparam logic [F:0] ONE_T = {1'b1, {F{1'b0}}};

    // configuration and table state
    logic signed [CW-1:0] start_reg  [NA];
    logic signed [CW-1:0] offset_reg [NA];
    logic signed [CW-1:0] seg0_reg   [NA];
    logic [CNT_W-1:0]     count_reg;
    logic                 table_full;
    logic                 do_store;

    logic [PT_W-1:0] ctrl_mem [MAX_SEGMENTS];
    logic [PT_W-1:0] end_mem  [MAX_SEGMENTS];
    logic [PT_W-1:0] ctrl_rd_reg;
    logic [PT_W-1:0] end_rd_reg;
    logic [PT_W-1:0] prev_rd_reg;

    // evaluation registers
    logic [F:0]       t_in;
    logic [F:0]       t_reg;
    logic [P_W-1:0]   p_reg;
    logic [CNT_W:0]   idx_raw;
    logic [CNT_W:0]   idx_clamp;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] prev_idx;
    logic [P_W-1:0]   u_full;
    logic [F:0]       u_next;
    logic [F:0]       u_reg;
    logic [F:0]       v_reg;
    logic             first_next;
    logic             first_reg;
    logic [F:0]       w0_reg;
    logic [F:0]       w1_reg;
    logic [F:0]       w2_reg;
    logic signed [PROD_W-1:0] sq_rnd_v;
    logic signed [PROD_W-1:0] sq_rnd_u;

    logic signed [WGT_W-1:0]  lane_wgt   [NA];
    logic signed [CW-1:0]     lane_coord [NA];
    logic signed [PROD_W-1:0] lane_prod  [NA];
    logic signed [CW-1:0]     lane_pos   [NA];

    // staged result and output register
    logic [1:0]      res_status_reg;
    logic [PT_W-1:0] res_pos_reg;
    logic            out_valid_reg;
    logic [1:0]      out_status_reg;
    logic [PT_W-1:0] out_pos_reg;

    assign table_full = (count_reg == CNT_W'(MAX_SEGMENTS));
    assign do_store   = cmd.take_item && (s_tuser == qbse_pkg::CMD_APPEND) && !table_full;

    assign stat.item_is_eval = (s_tuser == qbse_pkg::CMD_EVAL);
    assign stat.table_empty  = (count_reg == '0);
    assign stat.out_free     = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pos_reg;
    assign m_tuser  = out_status_reg;

    // t above one is treated as one
    always_comb
    begin
        t_in = s_tdata[T_LSB+F:T_LSB];
        if (t_in[F] && (t_in[F-1:0] != '0))
            t_in = ONE_T;
    end

    // segment index and local parameter from p = t * count
    always_comb
    begin
        idx_raw = p_reg[P_W-1:F];
        if (idx_raw >= {1'b0, count_reg})
            idx_clamp = {1'b0, count_reg} - (CNT_W+1)'(1);
        else
            idx_clamp = idx_raw;
        rd_idx     = idx_clamp[IDX_W-1:0];
        first_next = (idx_clamp == '0);
        prev_idx   = first_next ? '0 : rd_idx - IDX_W'(1);
        u_full     = p_reg - {idx_clamp, {F{1'b0}}};
        u_next     = u_full[F:0];
    end

    assign sq_rnd_v = lane_prod[0] + PROD_W'(SQ_HALF);
    assign sq_rnd_u = lane_prod[1] + PROD_W'(SQ_HALF);

    // control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NA; k++)
            begin
                start_reg[k]  <= '0;
                offset_reg[k] <= '0;
            end
        end
        else
        begin
            if (do_store)
                count_reg <= count_reg + CNT_W'(1);
            if (cmd.publish)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_addr)
                    qbse_pkg::CFG_START_X:  start_reg[0]  <= cfg_data;
                    qbse_pkg::CFG_START_Y:  start_reg[1]  <= cfg_data;
                    qbse_pkg::CFG_START_Z:  start_reg[2]  <= cfg_data;
                    qbse_pkg::CFG_OFFSET_X: offset_reg[0] <= cfg_data;
                    qbse_pkg::CFG_OFFSET_Y: offset_reg[1] <= cfg_data;
                    qbse_pkg::CFG_OFFSET_Z: offset_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // segment memories, one write port, registered reads
    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            ctrl_mem[count_reg[IDX_W-1:0]] <= s_tdata[PT_W-1:0];
            end_mem[count_reg[IDX_W-1:0]]  <= s_tdata[2*PT_W-1:PT_W];
        end
        if (cmd.op == qbse_pkg::OP_INDEX)
        begin
            ctrl_rd_reg <= ctrl_mem[rd_idx];
            end_rd_reg  <= end_mem[rd_idx];
            prev_rd_reg <= end_mem[prev_idx];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            if (s_tuser == qbse_pkg::CMD_APPEND)
            begin
                res_status_reg <= table_full ? qbse_pkg::STATUS_DROPPED
                                             : qbse_pkg::STATUS_STORED;
                res_pos_reg    <= '0;
                if (count_reg == '0)
                begin
                    for (int k = 0; k < NA; k++)
                        seg0_reg[k] <= start_reg[k];
                end
            end
            else
            begin
                res_status_reg <= qbse_pkg::STATUS_EVAL;
                res_pos_reg    <= {start_reg[2], start_reg[1], start_reg[0]};
                t_reg          <= t_in;
            end
        end
        case (cmd.op)
            qbse_pkg::OP_PROD:
            begin
                p_reg <= P_W'(t_reg) * P_W'(count_reg);
            end
            qbse_pkg::OP_INDEX:
            begin
                u_reg     <= u_next;
                v_reg     <= ONE_T - u_next;
                first_reg <= first_next;
            end
            qbse_pkg::OP_WEIGHT:
            begin
                w0_reg <= sq_rnd_v[2*F:F];
                w2_reg <= sq_rnd_u[2*F:F];
                w1_reg <= ONE_T - sq_rnd_v[2*F:F] - sq_rnd_u[2*F:F];
            end
            qbse_pkg::OP_FINISH:
            begin
                res_pos_reg <= {lane_pos[2], lane_pos[1], lane_pos[0]};
            end
            default: ;
        endcase
        if (cmd.publish)
        begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= res_pos_reg;
        end
    end

    // three coordinate lanes; squares use the x and y lanes
    for (genvar g = 0; g < NA; g++)
    begin : g_lane
        always_comb
        begin
            case (cmd.op)
                qbse_pkg::OP_SQUARE:
                begin
                    if (g == 0)
                    begin
                        lane_wgt[g]   = $signed({1'b0, v_reg});
                        lane_coord[g] = $signed({{(CW-F-1){1'b0}}, v_reg});
                    end
                    else
                    begin
                        lane_wgt[g]   = $signed({1'b0, u_reg});
                        lane_coord[g] = $signed({{(CW-F-1){1'b0}}, u_reg});
                    end
                end
                qbse_pkg::OP_MAC0:
                begin
                    lane_wgt[g]   = $signed({1'b0, w0_reg});
                    lane_coord[g] = first_reg ? seg0_reg[g] : $signed(prev_rd_reg[g*CW +: CW]);
                end
                qbse_pkg::OP_MAC1:
                begin
                    lane_wgt[g]   = $signed({1'b0, w1_reg});
                    lane_coord[g] = $signed(ctrl_rd_reg[g*CW +: CW]);
                end
                qbse_pkg::OP_MAC2:
                begin
                    lane_wgt[g]   = $signed({1'b0, w2_reg});
                    lane_coord[g] = $signed(end_rd_reg[g*CW +: CW]);
                end
                default:
                begin
                    lane_wgt[g]   = '0;
                    lane_coord[g] = '0;
                end
            endcase
        end

        qbse_lane #(
            .T_FRAC_BITS (T_FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .op     (cmd.op),
            .wgt    (lane_wgt[g]),
            .coord  (lane_coord[g]),
            .offset (offset_reg[g]),
            .prod   (lane_prod[g]),
            .pos    (lane_pos[g])
        );
    end

    // a dropped append leaves the table as it was
    a_drop_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_item && s_tuser == qbse_pkg::CMD_APPEND && table_full)
        |=> $stable(count_reg))
        else $error("dropped segment changed the table count");

    // a stored append grows the table by one
    a_store_counts_up: assert property (@(posedge clk) disable iff (!rst_n)
        do_store |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("stored segment did not advance the table count");

    // publishing fills the output register
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> m_tvalid)
        else $error("published result not presented");

endmodule

// ===== rtl/quadratic_bezier_spline_eval.sv =====
// quadratic_bezier_spline_eval: top level of the 3d quadratic bezier spline evaluator
// depends on qbse_pkg, qbse_ctrl, qbse_datapath (which holds qbse_lane)
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  tuser: cmd; tdata: ctrl xyz, end xyz, t_value
//  m_*       out  m_tvalid / m_tready  tuser: status; tdata: pos xyz
//  cfg_*     in   cfg_we               cfg_addr register index, cfg_data value
//
// an append request or an evaluate on an empty table goes from accept straight to
// the publish state, which loads the output register once it is free; an evaluate
// on a stored segment first steps through the t*count product, the index and memory
// read, the two squares and the weights, three weighted points on the coordinate
// lane multipliers, accumulation and rounding. a new request is taken only after the
// last result is published; s_tready is high only while the sequencer is idle.
// reset clears the controller, the segment count, the config registers and the
// output valid; segment memories are not cleared, since the count guards them.
// the output register holds one result; a new request is accepted while it waits,
// and the block holds its next result until m_tready frees the register.

module quadratic_bezier_spline_eval #(
    parameter int MAX_SEGMENTS = 16,
    parameter int T_FRAC_BITS  = 16
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic s_tvalid,
    output logic s_tready,
    // ctrl_x, ctrl_y, ctrl_z, end_x, end_y, end_z, t_value, zero fill
    input  logic [((6*qbse_pkg::COORD_W+T_FRAC_BITS+1+7)/8)*8-1:0] s_tdata,
    // cmd
    input  logic s_tuser,

    output logic m_tvalid,
    input  logic m_tready,
    // pos_x, pos_y, pos_z
    output logic [qbse_pkg::NUM_AXES*qbse_pkg::COORD_W-1:0] m_tdata,
    // status
    output logic [1:0] m_tuser,

    input  logic cfg_we,
    input  logic [qbse_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [qbse_pkg::COORD_W-1:0] cfg_data
);

    // command and status between the sequencer and the datapath
    qbse_pkg::qbse_cmd_t  cmd;
    qbse_pkg::qbse_stat_t stat;

    // sequencer: accept, evaluation steps, publish to the output register
    qbse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: segment table, weights, lanes and output register
    qbse_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .T_FRAC_BITS  (T_FRAC_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

endmodule

// ===== tb/sv/quadratic_bezier_spline_eval_tb.sv =====
// quadratic_bezier_spline_eval_tb: self-checking testbench of the 3d quadratic bezier spline evaluator
// depends on qbse_pkg and quadratic_bezier_spline_eval; a directed table runs first, then
// random appends and evaluates, scored against an in-bench spline predictor or typed-in results

module quadratic_bezier_spline_eval_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import qbse_pkg::*;

    localparam int MAX_SEG = 16;
    localparam int T_BITS = 16;
    localparam int S_DATA_W = ((6*COORD_W+T_BITS+1+7)/8)*8;
    localparam longint T_ONE = longint'(1) << T_BITS;
    localparam longint T_HALF = longint'(1) << (T_BITS-1);
    localparam logic [31:0] C_MAX = 32'h7fff_ffff;
    localparam logic [31:0] C_MIN = 32'h8000_0000;
    localparam int RAND_ITEMS = 450;
    localparam int PHASE_LEN = 50;

    // one request on the input stream; points are packed {z, y, x}
    typedef struct packed {
        logic                cmd;
        logic [2:0][31:0]    ctrl;
        logic [2:0][31:0]    tip;
        logic [T_BITS:0]     t_val;
    } req_t;

    // one result on the output stream
    typedef struct packed {
        logic [1:0]          status;
        logic [2:0][31:0]    pos;
    } result_t;

    // one row of the directed table: either a register write or a request
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [31:0]           reg_val;
        req_t                  req;
        logic                  known;
        result_t               want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;

    logic                  m_tvalid;
    logic                  m_tready;
    logic [NUM_AXES*COORD_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [COORD_W-1:0]    cfg_data;

    // predictor copy of the block state and registers
    int               table_count;
    logic [2:0][31:0] ctrl_pts [MAX_SEG];
    logic [2:0][31:0] end_pts [MAX_SEG];
    logic [2:0][31:0] origin_pt;
    logic [2:0][31:0] start_reg;
    logic [2:0][31:0] offset_reg;

    result_t   expected_points [$];
    plan_row_t plan [$];

    int  mismatches;
    int  requests_sent;
    int  reg_writes;
    int  evals_seen;
    int  stored_seen;
    int  dropped_seen;
    logic steady;

    quadratic_bezier_spline_eval #(
        .MAX_SEGMENTS (MAX_SEG),
        .T_FRAC_BITS  (T_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver back-pressure: random stalls on m_tready, none in the steady stretch
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= 9);
    end

    // expected response of the spline block to one request; updates the segment table
    function automatic result_t spline_response(input req_t r);
        result_t     resp;
        longint      t_q;
        longint      p;
        longint      u;
        longint      v;
        longint      w0;
        longint      w1;
        longint      w2;
        longint      acc;
        int          idx;
        logic [31:0] a;
        resp = '0;
        if (r.cmd == CMD_APPEND)
        begin
            if (table_count >= MAX_SEG)
            begin
                resp.status = STATUS_DROPPED;
                return resp;
            end
            // the first segment latches the start registers as its origin
            if (table_count == 0)
                origin_pt = start_reg;
            ctrl_pts[table_count] = r.ctrl;
            end_pts[table_count] = r.tip;
            table_count++;
            resp.status = STATUS_STORED;
            return resp;
        end
        resp.status = STATUS_EVAL;
        // empty table answers the live start registers, offset not applied
        if (table_count == 0)
        begin
            resp.pos = start_reg;
            return resp;
        end
        // t above one clamps to one
        t_q = (longint'(r.t_val) > T_ONE) ? T_ONE : longint'(r.t_val);
        p = t_q * table_count;
        idx = int'(p >>> T_BITS);
        if (idx >= table_count)
            idx = table_count - 1;
        u = p - (longint'(idx) <<< T_BITS);
        v = T_ONE - u;
        // bernstein weights rounded half up, middle one takes the remainder
        w0 = (v * v + T_HALF) >>> T_BITS;
        w2 = (u * u + T_HALF) >>> T_BITS;
        w1 = T_ONE - w0 - w2;
        for (int ax = 0; ax < 3; ax++)
        begin
            a = (idx == 0) ? origin_pt[ax] : end_pts[idx-1][ax];
            acc = w0 * longint'($signed(a))
                + w1 * longint'($signed(ctrl_pts[idx][ax]))
                + w2 * longint'($signed(end_pts[idx][ax]));
            // floor of (acc + half) / one, then offset and saturate to 32 bits
            acc = ((acc + T_HALF) >>> T_BITS) + longint'($signed(offset_reg[ax]));
            if (acc > 64'sd2147483647)
                resp.pos[ax] = C_MAX;
            else if (acc < -64'sd2147483648)
                resp.pos[ax] = C_MIN;
            else
                resp.pos[ax] = acc[31:0];
        end
        return resp;
    endfunction

    // random coordinate: extremes now and then, full-range words, mostly moderate values
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return C_MAX;
            1: return C_MIN;
            2, 3: return $urandom;
            default: return 32'($urandom_range(0, 32'h007f_ffff)) - 32'h0040_0000;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want_v, got_v);
    endtask

    task automatic plan_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.insert(plan.size(), row);
    endtask

    task automatic plan_req(input logic cmd, input logic [2:0][31:0] c,
                            input logic [2:0][31:0] e, input logic [T_BITS:0] t,
                            input logic known = 1'b0, input logic [1:0] st = STATUS_EVAL,
                            input logic [2:0][31:0] pos = '0);
        plan_row_t row;
        row = '0;
        row.req.cmd = cmd;
        row.req.ctrl = c;
        row.req.tip = e;
        row.req.t_val = t;
        row.known = known;
        row.want.status = st;
        row.want.pos = pos;
        plan.insert(plan.size(), row);
    endtask

    // present one request and hold it until accepted; typed-in result overrides the predictor
    task automatic push_req(input req_t r, input logic known, input result_t want);
        result_t resp;
        s_tvalid <= 1'b1;
        s_tuser <= r.cmd;
        s_tdata <= S_DATA_W'({r.t_val, r.tip, r.ctrl});
        do @(posedge clk); while (!s_tready);
        resp = spline_response(r);
        expected_points.insert(expected_points.size(), known ? want : resp);
        requests_sent++;
    endtask

    // stop sending and wait until every outstanding request has answered
    task automatic go_quiet();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_points.size() != 0);
    endtask

    // single-cycle register write, mirrored into the predictor
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_X:  start_reg[0] = val;
            CFG_START_Y:  start_reg[1] = val;
            CFG_START_Z:  start_reg[2] = val;
            CFG_OFFSET_X: offset_reg[0] = val;
            CFG_OFFSET_Y: offset_reg[1] = val;
            CFG_OFFSET_Z: offset_reg[2] = val;
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    // scoreboard: every result on the output stream against the oldest expectation
    always @(posedge clk)
    begin : check_points
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            case (m_tuser)
                STATUS_EVAL:    evals_seen++;
                STATUS_STORED:  stored_seen++;
                STATUS_DROPPED: dropped_seen++;
                default: ;
            endcase
            if (expected_points.size() == 0)
                flag_mismatch("result with no request pending", '0, m_tdata[31:0]);
            else
            begin
                want = expected_points.pop_front();
                if (m_tuser !== want.status)
                    flag_mismatch("status", 32'(want.status), 32'(m_tuser));
                for (int ax = 0; ax < 3; ax++)
                    if (m_tdata[ax*32 +: 32] !== want.pos[ax])
                        flag_mismatch($sformatf("pos axis %0d", ax), want.pos[ax],
                                      m_tdata[ax*32 +: 32]);
            end
        end
    end

    // hard stop far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_points.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        req_t             r;
        logic [2:0][31:0] off_set;
        logic             do_append;
        int               phase;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_APPEND;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_START_X;
        cfg_data = '0;
        steady = 1'b0;
        table_count = 0;
        origin_pt = '0;
        start_reg = '0;
        offset_reg = '0;
        mismatches = 0;
        requests_sent = 0;
        reg_writes = 0;
        evals_seen = 0;
        stored_seen = 0;
        dropped_seen = 0;

        // directed table; points written {z, y, x}
        // evaluate right after reset: empty table, start registers still zero
        plan_req(CMD_EVAL, '0, '0, 17'd0, 1'b1, STATUS_EVAL, '0);
        plan_cfg(CFG_START_X, C_MAX);
        plan_cfg(CFG_START_Y, C_MIN);
        plan_cfg(CFG_START_Z, 32'hffff_0000);
        plan_cfg(CFG_OFFSET_X, 32'h0001_0000);
        // empty table ignores the offset, also for t at one and above one
        plan_req(CMD_EVAL, '0, '0, 17'h1_0000, 1'b1, STATUS_EVAL,
                 {32'hffff_0000, C_MIN, C_MAX});
        plan_req(CMD_EVAL, '1, '1, 17'h1_ffff, 1'b1, STATUS_EVAL,
                 {32'hffff_0000, C_MIN, C_MAX});
        plan_cfg(CFG_START_X, C_MIN);
        plan_cfg(CFG_START_Y, C_MAX);
        plan_cfg(CFG_START_Z, 32'h0000_0000);
        plan_req(CMD_EVAL, '0, '0, 17'd1, 1'b1, STATUS_EVAL, {32'h0, C_MAX, C_MIN});
        plan_cfg(CFG_OFFSET_X, C_MAX);
        plan_cfg(CFG_OFFSET_Y, C_MIN);
        plan_cfg(CFG_OFFSET_Z, 32'h0000_0000);
        // first segment latches the start point just written
        plan_req(CMD_APPEND, {32'h1234_5678, C_MIN, C_MAX}, {32'hfedc_ba98, C_MIN, C_MAX},
                 17'h1_ffff, 1'b1, STATUS_STORED, '0);
        plan_req(CMD_EVAL, '0, '0, 17'd0);
        plan_req(CMD_EVAL, '0, '0, 17'h1_0000);
        plan_req(CMD_EVAL, '0, '0, 17'h1_ffff);
        plan_req(CMD_EVAL, '0, '0, 17'h0_8000);
        // offsets at the opposite extremes bring x and y back in range and push z into saturation
        plan_cfg(CFG_OFFSET_X, C_MIN);
        plan_cfg(CFG_OFFSET_Y, C_MAX);
        plan_cfg(CFG_OFFSET_Z, C_MAX);
        plan_req(CMD_EVAL, '0, '0, 17'h0_8000);
        plan_req(CMD_APPEND, '0, {C_MAX, C_MAX, C_MIN}, 17'd0, 1'b1, STATUS_STORED, '0);
        // two segments: t of one half lands exactly on the seam
        plan_req(CMD_EVAL, '0, '0, 17'h0_8000);
        plan_req(CMD_EVAL, '0, '0, 17'h1_0000);
        plan_req(CMD_EVAL, '0, '0, 17'd1);
        plan_req(CMD_EVAL, '0, '0, 17'h0_ffff);
        plan_req(CMD_APPEND, {32'h0000_8000, 32'hfffe_0000, 32'h0001_0000},
                 {32'hffff_8000, 32'h0003_0000, 32'h0002_0000}, 17'd0,
                 1'b1, STATUS_STORED, '0);
        plan_req(CMD_EVAL, '0, '0, 17'h0_5555);
        plan_req(CMD_EVAL, '0, '0, 17'h1_8000);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                go_quiet();
                cfg_write(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                push_req(plan[i].req, plan[i].known, plan[i].want);
        end

        // random part: appends are sparse early so every table size gets evaluated,
        // later frequent so the table fills and drops show up
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                // full drain before new register values
                go_quiet();
                phase = n / PHASE_LEN;
                case (phase % 5)
                    0: off_set = '0;
                    1: off_set = {3{C_MAX}};
                    2: off_set = {3{C_MIN}};
                    3: off_set = {$urandom, $urandom, $urandom};
                    default: off_set = {rand_coord(), rand_coord(), rand_coord()};
                endcase
                cfg_write(CFG_START_X, rand_coord());
                cfg_write(CFG_START_Y, rand_coord());
                cfg_write(CFG_START_Z, rand_coord());
                cfg_write(CFG_OFFSET_X, off_set[0]);
                cfg_write(CFG_OFFSET_Y, off_set[1]);
                cfg_write(CFG_OFFSET_Z, off_set[2]);
            end

            // a long stretch with no random idling on either side
            steady <= (n >= 150 && n < 250);
            if (!(n >= 150 && n < 250) && $urandom_range(0, 99) < 9)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else if (!(n >= 150 && n < 250) && $urandom_range(0, 59) == 0)
                go_quiet();

            do_append = (n < 300) ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 2) == 0);
            r.cmd = do_append ? CMD_APPEND : CMD_EVAL;
            r.ctrl = {rand_coord(), rand_coord(), rand_coord()};
            r.tip = {rand_coord(), rand_coord(), rand_coord()};
            case ($urandom_range(0, 19))
                0: r.t_val = '0;
                1: r.t_val = 17'h1_0000;
                2: r.t_val = 17'h0_ffff;
                3: r.t_val = 17'd1;
                4: r.t_val = 17'h1_ffff;
                5, 6: r.t_val = 17'($urandom_range(32'h1_0001, 32'h1_ffff));
                default: r.t_val = 17'($urandom_range(0, 32'h1_0000));
            endcase
            push_req(r, 1'b0, '0);
        end

        steady <= 1'b0;
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk);
        // room for any stray result after the last expected one
        repeat (30) @(posedge clk);

        $display("run covered %0d requests: %0d points evaluated, %0d segments stored, %0d appends dropped",
                 requests_sent, evals_seen, stored_seen, dropped_seen);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 reg_writes, RAND_ITEMS / PHASE_LEN + 1, mismatches);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
